/* rtl/tmch_pkg.sv */
// ----------------------------------------------------------------------------
// tmch_pkg
// Shared types and constants of the trimmed mean humidity block.
// ----------------------------------------------------------------------------
package tmch_pkg;

   // field widths
   localparam int CODE_W = 12;
   localparam int HUM_W  = 15;

   // humidity divider: dividend and quotient width, divisor width
   localparam int DIV_W  = 27;
   localparam int DSR_W  = 12;

   // scaling constants
   localparam logic [CODE_W-1:0] FULL_CODE = 12'd4095;
   localparam logic [CODE_W-1:0] FULL_MV   = 12'd3300;
   localparam logic [HUM_W-1:0]  HUM_FULL  = 15'd25600;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_CAL  = 2'd2;

   // register reset values
   localparam logic [CODE_W-1:0] DRY_RESET = 12'd4095;
   localparam logic [CODE_W-1:0] WET_RESET = 12'd0;

   // fixed humidity values
   typedef enum logic {
      HUM_ZERO,
      HUM_SAT
   } hum_src_type;

   // controller to datapath
   typedef struct packed {
      logic        sample_en;
      logic        sample_first;
      logic        trim_en;
      logic        mean_en;
      logic        mv_en;
      logic        div_start;
      logic        hum_set_en;
      hum_src_type hum_src;
      logic        rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic use_cal;
      logic mean_ge_dry;
      logic mean_le_wet;
   } dp_status_type;

endpackage

/* rtl/tmch_divider.sv */
// ----------------------------------------------------------------------------
// tmch_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmch_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tmch_pkg::DIV_W-1:0] dividend,
   input  logic [tmch_pkg::DSR_W-1:0] divisor,
   output logic                      done,
   output logic [tmch_pkg::DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(tmch_pkg::DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tmch_pkg::DIV_W - 1);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [tmch_pkg::DSR_W-1:0]  rem_ff;
   logic [tmch_pkg::DSR_W-1:0]  rem_in;
   logic [tmch_pkg::DSR_W-1:0]  dsr_ff;
   logic [tmch_pkg::DIV_W-1:0]  quo_ff;
   logic [tmch_pkg::DIV_W-1:0]  quo_in;
   logic [tmch_pkg::DSR_W:0]    trial;
   logic [tmch_pkg::DSR_W:0]    diff;
   logic                        fits;

   // one trial subtraction
   always_comb begin
      trial  = {rem_ff, quo_ff[tmch_pkg::DIV_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? diff[tmch_pkg::DSR_W-1:0] : trial[tmch_pkg::DSR_W-1:0];
      quo_in = {quo_ff[tmch_pkg::DIV_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // partial remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/tmch_datapath.sv */
// ----------------------------------------------------------------------------
// tmch_datapath
// Running sum and order-statistic trackers, calibration registers,
// reciprocal scaling, humidity divider and result registers.
// ----------------------------------------------------------------------------
module tmch_datapath #(
   parameter int SAMPLES = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tmch_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmch_pkg::CODE_W-1:0]     csr_wdata,
   input  logic [tmch_pkg::CODE_W-1:0]     sample,
   input  tmch_pkg::dp_cmd_type            cmd,
   output tmch_pkg::dp_status_type         status,
   output logic [tmch_pkg::HUM_W-1:0]      rsp_humidity,
   output logic [tmch_pkg::CODE_W-1:0]     rsp_millivolts,
   output logic [tmch_pkg::CODE_W-1:0]     rsp_mean
);

   localparam int CW    = tmch_pkg::CODE_W;
   localparam int SUM_W = $clog2(SAMPLES * 4095 + 1);

   // mean as trimmed sum times rounded-up reciprocal, exact over the sum range
   localparam int KEEP     = SAMPLES - 4;
   localparam int MEAN_SH  = SUM_W + $clog2(KEEP);
   localparam int MEAN_M_W = SUM_W + 2;
   localparam int MEAN_P_W = SUM_W + MEAN_M_W;
   localparam logic [MEAN_M_W-1:0] MEAN_RECIP =
      MEAN_M_W'(((64'd1 << MEAN_SH) + 64'(KEEP) - 64'd1) / 64'(KEEP));

   // millivolts as mean * 3300 / 4095 in one reciprocal multiply
   localparam int MV_SH   = 2 * CW;
   localparam int MV_P_W  = MV_SH + CW;
   localparam logic [MV_SH-1:0] MV_RECIP =
      MV_SH'(((64'(tmch_pkg::FULL_MV) << MV_SH) + 64'(tmch_pkg::FULL_CODE) - 64'd1)
             / 64'(tmch_pkg::FULL_CODE));

   // calibration registers
   logic [CW-1:0] dry_ff;
   logic [CW-1:0] wet_ff;
   logic          use_cal_ff;

   // batch trackers
   logic [SUM_W-1:0] sum_ff;
   logic [CW-1:0]    min1_ff;
   logic [CW-1:0]    min2_ff;
   logic [CW-1:0]    max1_ff;
   logic [CW-1:0]    max2_ff;

   // intermediate and result values
   logic [SUM_W-1:0]             trim_ff;
   logic [CW-1:0]                mean_ff;
   logic [CW-1:0]                mv_ff;
   logic [tmch_pkg::HUM_W-1:0]   hum_ff;
   logic [tmch_pkg::HUM_W-1:0]   rsp_hum_ff;
   logic [CW-1:0]                rsp_mv_ff;
   logic [CW-1:0]                rsp_mean_ff;

   // scaling and divider interface
   logic [SUM_W-1:0]              low_pair;
   logic [SUM_W-1:0]              high_pair;
   logic [SUM_W-1:0]              trim_sum;
   logic [MEAN_P_W-1:0]           mean_prod;
   logic [MV_P_W-1:0]             mv_prod;
   logic [CW-1:0]                 hum_diff;
   logic [tmch_pkg::DIV_W-1:0]    hum_prod;
   logic [tmch_pkg::DSR_W-1:0]    hum_span;
   logic                          div_done;
   logic [tmch_pkg::DIV_W-1:0]    div_quotient;

   // configuration writes, other indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         dry_ff     <= tmch_pkg::DRY_RESET;
         wet_ff     <= tmch_pkg::WET_RESET;
         use_cal_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            tmch_pkg::CSR_DRY_CODE: dry_ff     <= csr_wdata;
            tmch_pkg::CSR_WET_CODE: wet_ff     <= csr_wdata;
            tmch_pkg::CSR_USE_CAL:  use_cal_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sum plus two smallest and two largest of the batch so far
   always_ff @(posedge clock) begin
      if (cmd.sample_en) begin
         if (cmd.sample_first) begin
            sum_ff  <= SUM_W'(sample);
            min1_ff <= sample;
            min2_ff <= '1;
            max1_ff <= sample;
            max2_ff <= '0;
         end else begin
            sum_ff <= sum_ff + SUM_W'(sample);
            if (sample < min1_ff) begin
               min2_ff <= min1_ff;
               min1_ff <= sample;
            end else if (sample < min2_ff) begin
               min2_ff <= sample;
            end
            if (sample > max1_ff) begin
               max2_ff <= max1_ff;
               max1_ff <= sample;
            end else if (sample > max2_ff) begin
               max2_ff <= sample;
            end
         end
      end
   end

   // trimmed sum, scaling products and divider operands
   always_comb begin
      low_pair  = SUM_W'(min1_ff) + SUM_W'(min2_ff);
      high_pair = SUM_W'(max1_ff) + SUM_W'(max2_ff);
      trim_sum  = sum_ff - (low_pair + high_pair);
      mean_prod = MEAN_P_W'(trim_ff) * MEAN_P_W'(MEAN_RECIP);
      mv_prod   = MV_P_W'(mean_ff) * MV_P_W'(MV_RECIP);
      hum_diff  = dry_ff - mean_ff;
      hum_prod  = tmch_pkg::DIV_W'(hum_diff) * tmch_pkg::DIV_W'(tmch_pkg::HUM_FULL);
      hum_span  = dry_ff - wet_ff;
   end

   tmch_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (hum_prod),
      .divisor  (hum_span),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // capture trimmed sum, mean, millivolts, humidity and result
   always_ff @(posedge clock) begin
      if (cmd.trim_en) begin
         trim_ff <= trim_sum;
      end
      if (cmd.mean_en) begin
         mean_ff <= mean_prod[MEAN_SH +: CW];
      end
      if (cmd.mv_en) begin
         mv_ff <= mv_prod[MV_SH +: CW];
      end
      if (div_done) begin
         hum_ff <= div_quotient[tmch_pkg::HUM_W-1:0];
      end else if (cmd.hum_set_en) begin
         hum_ff <= (cmd.hum_src == tmch_pkg::HUM_SAT) ? tmch_pkg::HUM_FULL : '0;
      end
      if (cmd.rsp_load) begin
         rsp_hum_ff  <= hum_ff;
         rsp_mv_ff   <= mv_ff;
         rsp_mean_ff <= mean_ff;
      end
   end

   // status back to the controller
   always_comb begin
      status.div_done    = div_done;
      status.use_cal     = use_cal_ff;
      status.mean_ge_dry = mean_ff >= dry_ff;
      status.mean_le_wet = mean_ff <= wet_ff;
   end

   assign rsp_humidity   = rsp_hum_ff;
   assign rsp_millivolts = rsp_mv_ff;
   assign rsp_mean       = rsp_mean_ff;

endmodule

/* rtl/tmch_ctrl.sv */
// ----------------------------------------------------------------------------
// tmch_ctrl
// Sequencer: batch fill count, scaling and divide sequence, result handshake.
// ----------------------------------------------------------------------------
module tmch_ctrl #(
   parameter int SAMPLES = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_failed,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output tmch_pkg::dp_cmd_type     cmd,
   input  tmch_pkg::dp_status_type  status
);

   localparam int FILL_W = $clog2(SAMPLES + 1);
   localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(SAMPLES - 1);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_TRIM,
      ST_MEAN,
      ST_MV,
      ST_HUM_CHECK,
      ST_HUM_WAIT,
      ST_OUTPUT
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              rsp_valid_ff;
   logic              accept;
   logic              out_free;

   assign accept   = req_tvalid && (state_ff == ST_COLLECT);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state and datapath commands
   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      cmd              = '0;
      cmd.hum_src      = tmch_pkg::HUM_ZERO;
      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (req_failed) begin
                  fill_in = '0;
               end else begin
                  cmd.sample_en    = 1'b1;
                  cmd.sample_first = (fill_ff == '0);
                  if (fill_ff == LAST_FILL) begin
                     fill_in  = '0;
                     state_in = ST_TRIM;
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
         end
         ST_TRIM: begin
            cmd.trim_en = 1'b1;
            state_in    = ST_MEAN;
         end
         ST_MEAN: begin
            cmd.mean_en = 1'b1;
            state_in    = ST_MV;
         end
         ST_MV: begin
            cmd.mv_en = 1'b1;
            state_in  = ST_HUM_CHECK;
         end
         ST_HUM_CHECK: begin
            // dry test first, so an inverted calibration reads dry or saturated
            if (!status.use_cal || status.mean_ge_dry) begin
               cmd.hum_set_en = 1'b1;
               cmd.hum_src    = tmch_pkg::HUM_ZERO;
               state_in       = ST_OUTPUT;
            end else if (status.mean_le_wet) begin
               cmd.hum_set_en = 1'b1;
               cmd.hum_src    = tmch_pkg::HUM_SAT;
               state_in       = ST_OUTPUT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_HUM_WAIT;
            end
         end
         ST_HUM_WAIT: begin
            if (status.div_done) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // state, fill count and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= (rsp_valid_ff && !rsp_tready) || cmd.rsp_load;
      end
   end

   assign req_tready = (state_ff == ST_COLLECT);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/trimmed_mean_calibrated_humidity.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_calibrated_humidity
// Trimmed mean of a batch of ADC samples with millivolt and humidity output.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one ADC sample per item; req_tuser flags a failed
//   conversion, which drops the partial batch and gives no result.
//   Samples are taken one per cycle while a batch fills. The item that
//   completes a batch of SAMPLES starts the end-of-batch work: a running
//   sum and two-smallest / two-largest trackers give the trimmed sum,
//   reciprocal multiplies give the mean and the millivolts, and a
//   27-step serial divider forms the humidity when it lies between the
//   calibration points. req_tready stays low after the last sample of a
//   batch through the trim, mean, millivolt, humidity check, divider wait
//   (when it runs) and output states, so no new sample is taken until
//   the result is loaded. rsp_* holds one result item per batch in an
//   output register; if the receiver stalls, the next batch is still
//   collected and the block waits only when a further result is ready.
//   csr_* writes dry_code, wet_code and use_calibration; the user must do
//   so only while idle, as the block does not enforce it. Reset empties
//   the batch, drops any pending result and restores the register defaults.
// ----------------------------------------------------------------------------
module trimmed_mean_calibrated_humidity #(
   parameter int SAMPLES = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   // sample [11:0], zero pad [15:12]
   input  logic [15:0]                    req_tdata,
   // conversion_failed [0]
   input  logic                           req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // humidity_q8 [14:0], millivolts [26:15], mean_code [38:27], zero pad [39]
   output logic [39:0]                    rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  logic [tmch_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tmch_pkg::CODE_W-1:0]    csr_wdata
);

   tmch_pkg::dp_cmd_type            cmd;
   tmch_pkg::dp_status_type         status;
   logic [tmch_pkg::HUM_W-1:0]      rsp_humidity;
   logic [tmch_pkg::CODE_W-1:0]     rsp_millivolts;
   logic [tmch_pkg::CODE_W-1:0]     rsp_mean;

   tmch_ctrl #(
      .SAMPLES (SAMPLES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_failed (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tmch_datapath #(
      .SAMPLES (SAMPLES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .sample         (req_tdata[tmch_pkg::CODE_W-1:0]),
      .cmd            (cmd),
      .status         (status),
      .rsp_humidity   (rsp_humidity),
      .rsp_millivolts (rsp_millivolts),
      .rsp_mean       (rsp_mean)
   );

   // result packing
   assign rsp_tdata = {1'b0, rsp_mean, rsp_millivolts, rsp_humidity};

endmodule
